// ----- src/dihe_pkg.sv -----
package dihe_pkg;

   // integrator limits
   localparam int COUNT_MAX = 8;
   localparam int COUNT_MIN = 0;
   localparam int INTEG_W   = 4;
   localparam logic [INTEG_W-1:0] INTEG_TOP =
      INTEG_W'((COUNT_MAX < 15) ? COUNT_MAX : 15);
   localparam logic [INTEG_W-1:0] INTEG_BOTTOM = INTEG_W'(COUNT_MIN);

   localparam int HOLD_W = 16;
   localparam logic [HOLD_W-1:0] HOLD_SAT = '1;

   localparam int MASK_W = 10;
   localparam int PEND_W = 7;

   // csr port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_ACTIVE_LEVEL  = 3'd0,
      REG_ON_THRESHOLD  = 3'd1,
      REG_OFF_THRESHOLD = 3'd2,
      REG_SHORT_DELAY   = 3'd3,
      REG_MID_DELAY     = 3'd4,
      REG_LONG_DELAY    = 3'd5,
      REG_REPEAT_START  = 3'd6,
      REG_REPEAT_PERIOD = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_MANAGE = 2'd1,
      ACT_HOLD   = 2'd2
   } action_type;

   // event mask bit positions
   localparam int EV_CHANGE     = 0;
   localparam int EV_WORK       = 1;
   localparam int EV_IDLE       = 2;
   localparam int EV_PEND_BASE  = 3;

   // pending event bit positions
   localparam int PEND_WORK_SHORT = 0;
   localparam int PEND_IDLE_SHORT = 1;
   localparam int PEND_WORK_MID   = 2;
   localparam int PEND_IDLE_MID   = 3;
   localparam int PEND_WORK_LONG  = 4;
   localparam int PEND_IDLE_LONG  = 5;
   localparam int PEND_AUTOFIRE   = 6;

   typedef struct packed {
      logic                    active_level;
      logic [INTEG_W-1:0]      on_threshold;
      logic [INTEG_W-1:0]      off_threshold;
      logic [HOLD_W-1:0]       short_delay;
      logic [HOLD_W-1:0]       mid_delay;
      logic [HOLD_W-1:0]       long_delay;
      logic [HOLD_W-1:0]       repeat_start;
      logic [HOLD_W-1:0]       repeat_period;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      active_level:  1'b0,
      on_threshold:  INTEG_W'(6),
      off_threshold: INTEG_W'(3),
      short_delay:   HOLD_W'(10),
      mid_delay:     HOLD_W'(30),
      long_delay:    HOLD_W'(100),
      repeat_start:  HOLD_W'(20),
      repeat_period: HOLD_W'(5)
   };

   typedef struct packed {
      logic                    debounced_state;
      logic [MASK_W-1:0]       event_mask;
      logic [HOLD_W-1:0]       hold_count;
   } result_type;

endpackage

// ----- src/dihe_csr.sv -----
module dihe_csr
   import dihe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_ACTIVE_LEVEL:  cfg_in.active_level  = pwdata[0];
            REG_ON_THRESHOLD:  cfg_in.on_threshold  = pwdata[INTEG_W-1:0];
            REG_OFF_THRESHOLD: cfg_in.off_threshold = pwdata[INTEG_W-1:0];
            REG_SHORT_DELAY:   cfg_in.short_delay   = pwdata[HOLD_W-1:0];
            REG_MID_DELAY:     cfg_in.mid_delay     = pwdata[HOLD_W-1:0];
            REG_LONG_DELAY:    cfg_in.long_delay    = pwdata[HOLD_W-1:0];
            REG_REPEAT_START:  cfg_in.repeat_start  = pwdata[HOLD_W-1:0];
            REG_REPEAT_PERIOD: cfg_in.repeat_period = pwdata[HOLD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ACTIVE_LEVEL:  prdata = CSR_DATA_W'(cfg_ff.active_level);
         REG_ON_THRESHOLD:  prdata = CSR_DATA_W'(cfg_ff.on_threshold);
         REG_OFF_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.off_threshold);
         REG_SHORT_DELAY:   prdata = CSR_DATA_W'(cfg_ff.short_delay);
         REG_MID_DELAY:     prdata = CSR_DATA_W'(cfg_ff.mid_delay);
         REG_LONG_DELAY:    prdata = CSR_DATA_W'(cfg_ff.long_delay);
         REG_REPEAT_START:  prdata = CSR_DATA_W'(cfg_ff.repeat_start);
         REG_REPEAT_PERIOD: prdata = CSR_DATA_W'(cfg_ff.repeat_period);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/dihe_core.sv -----
module dihe_core
   import dihe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] action,
   input  logic       pin_level,
   input  cfg_type    cfg,
   output result_type result
);

   logic [INTEG_W-1:0] integ_ff, integ_in;
   logic               state_ff, state_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [HOLD_W-1:0]  phase_ff, phase_in;
   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic [MASK_W-1:0]  mask;

   action_type         act;
   logic               steady;
   logic               advanced;
   logic               next_state;
   logic [HOLD_W-1:0]  hold_inc;
   logic [HOLD_W:0]    phase_step;

   assign act      = action_type'(action);
   assign steady   = state_ff ? (integ_ff >= cfg.on_threshold)
                              : (integ_ff < cfg.off_threshold);
   assign advanced = (hold_ff != HOLD_SAT);
   assign hold_inc = advanced ? hold_ff + HOLD_W'(1) : hold_ff;
   assign phase_step = {1'b0, phase_ff} + (HOLD_W+1)'(1);
   assign next_state = state_ff ? !(integ_ff < cfg.off_threshold)
                                : (integ_ff >= cfg.on_threshold);

   always_comb begin
      integ_in = integ_ff;
      state_in = state_ff;
      hold_in  = hold_ff;
      phase_in = phase_ff;
      pend_in  = pend_ff;
      mask     = '0;
      unique case (act)
         ACT_SAMPLE: begin
            if (pin_level == cfg.active_level) begin
               if (integ_ff < INTEG_TOP) integ_in = integ_ff + INTEG_W'(1);
            end else begin
               if (integ_ff > INTEG_BOTTOM) integ_in = integ_ff - INTEG_W'(1);
            end
         end
         ACT_MANAGE: begin
            if (next_state != state_ff) begin
               mask[EV_CHANGE] = 1'b1;
               mask[EV_WORK]   = next_state;
               mask[EV_IDLE]   = !next_state;
               hold_in         = '0;
               phase_in        = '0;
            end
            state_in = next_state;
            mask[EV_PEND_BASE +: PEND_W] = pend_ff;
            pend_in  = '0;
         end
         ACT_HOLD: begin
            if (steady) begin
               hold_in = hold_inc;
               if (state_ff) begin
                  if (hold_inc == cfg.short_delay) pend_in[PEND_WORK_SHORT] = 1'b1;
                  if (hold_inc == cfg.mid_delay)   pend_in[PEND_WORK_MID]   = 1'b1;
                  if (hold_inc == cfg.long_delay)  pend_in[PEND_WORK_LONG]  = 1'b1;
                  if (advanced) begin
                     if (hold_inc == cfg.repeat_start) begin
                        phase_in = '0;
                     end else if (hold_inc > cfg.repeat_start) begin
                        // period zero acts as one
                        phase_in = (phase_step >= {1'b0, cfg.repeat_period})
                                 ? '0 : phase_step[HOLD_W-1:0];
                     end
                  end
                  if (hold_inc >= cfg.repeat_start && phase_in == '0)
                     pend_in[PEND_AUTOFIRE] = 1'b1;
               end else begin
                  if (hold_inc == cfg.short_delay) pend_in[PEND_IDLE_SHORT] = 1'b1;
                  if (hold_inc == cfg.mid_delay)   pend_in[PEND_IDLE_MID]   = 1'b1;
                  if (hold_inc == cfg.long_delay)  pend_in[PEND_IDLE_LONG]  = 1'b1;
               end
            end
         end
         default: begin
            mask = '0;
         end
      endcase
   end

   assign result.debounced_state = state_in;
   assign result.event_mask      = mask;
   assign result.hold_count      = hold_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         state_ff <= 1'b0;
         hold_ff  <= '0;
         phase_ff <= '0;
         pend_ff  <= '0;
      end else if (step) begin
         integ_ff <= integ_in;
         state_ff <= state_in;
         hold_ff  <= hold_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- src/debounced_input_hold_events_unit.sv -----
// an accepted req word passes through the input register, then the result register, before its rsp word
// throughput: one word per cycle while the result register is empty or rsp_stall is low
// reset: synchronous, active high; clears the debounce state, the pipeline valids and
// restores every csr register to its default value
// no clearing pass, the block takes words right after reset
module debounced_input_hold_events_unit
   import dihe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic                  req_pin_level,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_debounced_state,
   output logic [MASK_W-1:0]     rsp_event_mask,
   output logic [HOLD_W-1:0]     rsp_hold_count,
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type result;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_action_ff;
   logic       in_pin_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       out_free;   // result register can load this cycle
   logic       advance;    // word in the input register moves into the result register
   logic       req_take;

   dihe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // state is updated at the same edge the result register loads, so the
   // next word in the input register already sees the new state
   dihe_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .action    (in_action_ff),
      .pin_level (in_pin_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   // input register empties or moves on; holds one word while the result waits
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_pin_ff    <= req_pin_level;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_debounced_state = out_ff.debounced_state;
   assign rsp_event_mask      = out_ff.event_mask;
   assign rsp_hold_count      = out_ff.hold_count;

endmodule
